FILE: rtl/assert_macros.svh
// Assertion macros shared by the laser scan projection RTL.
// No dependencies; include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is active
`define LSC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error(msg);

// Clocked check that also holds during reset
`define LSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/lsc_pkg.sv
// Types and constants for the laser scan to Cartesian points unit.
// No dependencies; imported by every module of the unit.
`default_nettype none

package lsc_pkg;

	localparam int CORDIC_MAX = 24;
	localparam int XY_W       = 18;
	localparam int Z_W        = 32;
	localparam int TRIG_W     = 16;
	localparam int PROD_W     = 33;
	localparam int COORD_W    = 17;
	localparam int DATA_W     = 16;
	localparam int ANGLE_W    = 32;
	localparam int CFG_IDX_W  = 3;

	localparam logic signed [XY_W-1:0]    CORDIC_GAIN = 18'sd19898;
	localparam logic signed [XY_W-1:0]    TRIG_MAX    = 18'sd32767;
	localparam logic signed [PROD_W:0]    COORD_MAX   = 34'sd65535;
	localparam logic signed [PROD_W:0]    ROUND_HALF  = 34'sd16384;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_END   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = 3'd4;

	// Arc tangent of 2^-i as a fraction of a full turn (2^32 per turn)
	typedef logic [Z_W-1:0] atan_tab_t [CORDIC_MAX];
	localparam atan_tab_t ATAN_TURN = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Configuration register set
	typedef struct packed {
		logic signed [DATA_W-1:0] angle_start;
		logic [DATA_W-1:0]        angle_step;
		logic signed [DATA_W-1:0] angle_end;
		logic [DATA_W-1:0]        range_low;
		logic [DATA_W-1:0]        range_high;
	} lsc_cfg_t;

	// One beam travelling down the rotation chain
	typedef struct packed {
		logic                     pt_valid;
		logic                     flip;
		logic signed [XY_W-1:0]   x;
		logic signed [XY_W-1:0]   y;
		logic signed [Z_W-1:0]    z;
		logic [DATA_W-1:0]        range;
		logic [DATA_W-1:0]        inten;
	} lsc_beam_t;

endpackage

`default_nettype wire

FILE: rtl/lsc_front.sv
// Beam angle accumulator, limit checks and quadrant folding.
// Depends on lsc_pkg; feeds the first rotation cell.
`default_nettype none

module lsc_front #(
	parameter logic [15:0] RANGE_MASK = 16'hFFFF,
	parameter logic [15:0] ANGLE_MASK = 16'hFFFF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  lsc_pkg::lsc_cfg_t         cfg,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire [15:0]                range_mm,
	input  wire [15:0]                echo_intensity,
	input  wire                       scan_start,
	output logic                      out_valid,
	input  wire                       out_ready,
	output lsc_pkg::lsc_beam_t        out_beam
);
	import lsc_pkg::*;

	logic signed [ANGLE_W-1:0] angle_q;
	logic                      valid_q;
	lsc_beam_t                 beam_q;

	logic signed [ANGLE_W:0]   sum_ext;
	logic signed [ANGLE_W-1:0] angle_next;
	logic signed [ANGLE_W-1:0] end_ext;
	logic [DATA_W-1:0]         range_m;
	logic [DATA_W-1:0]         phase16;
	logic                      flip;
	logic                      take;
	lsc_beam_t                 beam_d;

	assign in_ready = !valid_q || out_ready;
	assign take     = in_valid && in_ready;

	// Advance the running angle, or reload angle_start on scan_start, saturating at the top of the 32 bit range
	always_comb begin
		sum_ext = {angle_q[ANGLE_W-1], angle_q} + {{(ANGLE_W+1-DATA_W){1'b0}}, cfg.angle_step};
		if (scan_start) begin
			angle_next = {{(ANGLE_W-DATA_W){cfg.angle_start[DATA_W-1]}}, cfg.angle_start};
		end else if (sum_ext[ANGLE_W] != sum_ext[ANGLE_W-1]) begin
			angle_next = {1'b0, {(ANGLE_W-1){1'b1}}};
		end else begin
			angle_next = sum_ext[ANGLE_W-1:0];
		end
	end

	// Limit checks and folding of the phase into the right half plane
	always_comb begin
		end_ext = {{(ANGLE_W-DATA_W){cfg.angle_end[DATA_W-1]}}, cfg.angle_end};
		range_m = range_mm & RANGE_MASK;
		phase16 = angle_next[DATA_W-1:0] & ANGLE_MASK;
		flip    = phase16[DATA_W-1] ^ phase16[DATA_W-2];

		beam_d.pt_valid = (angle_next <= end_ext) && (range_m > cfg.range_low)
			&& (range_m < cfg.range_high);
		beam_d.flip     = flip;
		beam_d.x        = CORDIC_GAIN;
		beam_d.y        = '0;
		beam_d.z        = {phase16[DATA_W-1] ^ flip, phase16[DATA_W-2:0],
			{(Z_W-DATA_W){1'b0}}};
		beam_d.range    = range_m;
		beam_d.inten    = echo_intensity;
	end

	// Hold the angle between requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				angle_q <= angle_next;
			end
			if (in_ready) begin
				valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			beam_q <= beam_d;
		end
	end

	assign out_valid = valid_q;
	assign out_beam  = beam_q;

endmodule

`default_nettype wire

FILE: rtl/lsc_cordic_cell.sv
// One rotation cell of the CORDIC chain, shift and arc tangent set by IDX.
// Depends on lsc_pkg; cells are chained in the top level.
`default_nettype none

module lsc_cordic_cell #(
	parameter int IDX = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  lsc_pkg::lsc_beam_t  in_beam,
	output logic                out_valid,
	input  wire                 out_ready,
	output lsc_pkg::lsc_beam_t  out_beam
);
	import lsc_pkg::*;

	localparam logic signed [Z_W-1:0] ATAN = ATAN_TURN[IDX];

	logic                   valid_q;
	lsc_beam_t              beam_q;
	lsc_beam_t              beam_d;
	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;

	assign in_ready = !valid_q || out_ready;

	// Rotate toward the residual phase
	always_comb begin
		dx     = in_beam.y >>> IDX;
		dy     = in_beam.x >>> IDX;
		beam_d = in_beam;
		if (!in_beam.z[Z_W-1]) begin
			beam_d.x = in_beam.x - dx;
			beam_d.y = in_beam.y + dy;
			beam_d.z = in_beam.z - ATAN;
		end else begin
			beam_d.x = in_beam.x + dx;
			beam_d.y = in_beam.y - dy;
			beam_d.z = in_beam.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beam_q <= beam_d;
		end
	end

	assign out_valid = valid_q;
	assign out_beam  = beam_q;

endmodule

`default_nettype wire

FILE: rtl/lsc_scale.sv
// Unfold, clamp, scale by range and round into millimetre coordinates.
// Depends on lsc_pkg; its last stage is the output register of the unit.
`default_nettype none

module lsc_scale (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  lsc_pkg::lsc_beam_t  in_beam,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic                pt_valid,
	output logic signed [16:0]  x_mm,
	output logic signed [16:0]  y_mm,
	output logic [15:0]         pt_inten
);
	import lsc_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic                     pv_s1, pv_s2;
	logic [DATA_W-1:0]        rng_s1;
	logic [DATA_W-1:0]        int_s1, int_s2;
	logic signed [TRIG_W-1:0] c_s1, s_s1;
	logic signed [PROD_W-1:0] px_s2, py_s2;

	logic signed [XY_W-1:0]   xf, yf;
	logic signed [TRIG_W-1:0] c_d, s_d;
	logic signed [PROD_W:0]   rx, ry;
	logic signed [PROD_W:0]   shx, shy;
	logic signed [COORD_W-1:0] cx_d, cy_d;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Undo the half turn and clamp to the Q1.15 range
	always_comb begin
		xf = in_beam.flip ? -in_beam.x : in_beam.x;
		yf = in_beam.flip ? -in_beam.y : in_beam.y;
		if (xf > TRIG_MAX) begin
			c_d = TRIG_MAX[TRIG_W-1:0];
		end else if (xf < -TRIG_MAX) begin
			c_d = -TRIG_MAX[TRIG_W-1:0];
		end else begin
			c_d = xf[TRIG_W-1:0];
		end
		if (yf > TRIG_MAX) begin
			s_d = TRIG_MAX[TRIG_W-1:0];
		end else if (yf < -TRIG_MAX) begin
			s_d = -TRIG_MAX[TRIG_W-1:0];
		end else begin
			s_d = yf[TRIG_W-1:0];
		end
	end

	// Round to millimetres and saturate
	always_comb begin
		rx  = {px_s2[PROD_W-1], px_s2} + ROUND_HALF;
		ry  = {py_s2[PROD_W-1], py_s2} + ROUND_HALF;
		shx = rx >>> 15;
		shy = ry >>> 15;
		if (shx > COORD_MAX) begin
			cx_d = COORD_MAX[COORD_W-1:0];
		end else if (shx < -COORD_MAX) begin
			cx_d = -COORD_MAX[COORD_W-1:0];
		end else begin
			cx_d = shx[COORD_W-1:0];
		end
		if (shy > COORD_MAX) begin
			cy_d = COORD_MAX[COORD_W-1:0];
		end else if (shy < -COORD_MAX) begin
			cy_d = -COORD_MAX[COORD_W-1:0];
		end else begin
			cy_d = shy[COORD_W-1:0];
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			pv_s1  <= in_beam.pt_valid;
			rng_s1 <= in_beam.range;
			int_s1 <= in_beam.inten;
			c_s1   <= c_d;
			s_s1   <= s_d;
		end
		if (v_s1 && rdy_s2) begin
			pv_s2  <= pv_s1;
			int_s2 <= int_s1;
			px_s2  <= PROD_W'($signed({1'b0, rng_s1}) * c_s1);
			py_s2  <= PROD_W'($signed({1'b0, rng_s1}) * s_s1);
		end
		if (v_s2 && rdy_s3) begin
			pt_valid <= pv_s2;
			x_mm     <= pv_s2 ? cx_d : '0;
			y_mm     <= pv_s2 ? cy_d : '0;
			pt_inten <= pv_s2 ? int_s2 : '0;
		end
	end

	assign out_valid = v_s3;

endmodule

`default_nettype wire

FILE: rtl/laser_scan_to_cartesian_points_unit.sv
// Laser scan to Cartesian points: a chain of CORDIC cells between an angle front end
// and a scale back end; a request passes the front register, the cells and the scale
// stages in turn. Throughput one beam per cycle; each cell and stage hands on one beam
// per cycle and stalls only when the one after it is full. Asynchronous active-low reset
// empties the chain, zeroes the running angle and loads the register reset values.
`default_nettype none

module laser_scan_to_cartesian_points_unit #(
	parameter int RANGE_BITS  = 16,
	parameter int ANGLE_BITS  = 16,
	parameter int TRIG_STAGES = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // range_mm[15:0], echo_intensity[31:16]
	input  wire         s_tuser,   // scan_start
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata,   // x_mm[16:0], y_mm[33:17], point_intensity[49:34], zero
	output logic        m_tuser    // point_valid
);
	import lsc_pkg::*;

	`include "assert_macros.svh"

	localparam int N_CELLS = (TRIG_STAGES > CORDIC_MAX) ? CORDIC_MAX : TRIG_STAGES;
	localparam logic [15:0] RANGE_MASK = (RANGE_BITS >= 16) ? 16'hFFFF
		: 16'((32'd1 << RANGE_BITS) - 32'd1);
	localparam int ANGLE_DROP = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
	localparam logic [15:0] ANGLE_MASK = ~(16'((32'd1 << ANGLE_DROP) - 32'd1));

	lsc_cfg_t cfg_q;

	logic [N_CELLS:0] stg_valid;
	logic [N_CELLS:0] stg_ready;
	lsc_beam_t        stg_beam [N_CELLS+1];

	logic signed [16:0] x_mm;
	logic signed [16:0] y_mm;
	logic [15:0]        pt_inten;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_start <= 16'sh8000;
			cfg_q.angle_step  <= 16'd182;
			cfg_q.angle_end   <= 16'sh7FFF;
			cfg_q.range_low   <= 16'd0;
			cfg_q.range_high  <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ANGLE_START: cfg_q.angle_start <= cfg_data;
				REG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_data;
				REG_ANGLE_END:   cfg_q.angle_end   <= cfg_data;
				REG_RANGE_LOW:   cfg_q.range_low   <= cfg_data;
				REG_RANGE_HIGH:  cfg_q.range_high  <= cfg_data;
				default: ;
			endcase
		end
	end

	lsc_front #(
		.RANGE_MASK(RANGE_MASK),
		.ANGLE_MASK(ANGLE_MASK)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.range_mm       (s_tdata[15:0]),
		.echo_intensity (s_tdata[31:16]),
		.scan_start     (s_tuser),
		.out_valid      (stg_valid[0]),
		.out_ready      (stg_ready[0]),
		.out_beam       (stg_beam[0])
	);

	// Rotation chain
	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		lsc_cordic_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[i]),
			.in_ready  (stg_ready[i]),
			.in_beam   (stg_beam[i]),
			.out_valid (stg_valid[i+1]),
			.out_ready (stg_ready[i+1]),
			.out_beam  (stg_beam[i+1])
		);
	end

	lsc_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stg_valid[N_CELLS]),
		.in_ready  (stg_ready[N_CELLS]),
		.in_beam   (stg_beam[N_CELLS]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.pt_valid  (m_tuser),
		.x_mm      (x_mm),
		.y_mm      (y_mm),
		.pt_inten  (pt_inten)
	);

	assign m_tdata = {6'b0, pt_inten, y_mm, x_mm};

	// Checks
	`LSC_ASSERT(a_invalid_zero, clk, arst_n, (m_tvalid && !m_tuser) |-> (m_tdata == 56'd0), "invalid point carries nonzero fields")
	`LSC_ASSERT(a_x_sat, clk, arst_n, m_tvalid |-> (m_tdata[16:0] != 17'h10000), "x coordinate beyond saturation limit")
	`LSC_ASSERT(a_y_sat, clk, arst_n, m_tvalid |-> (m_tdata[33:17] != 17'h10000), "y coordinate beyond saturation limit")
	`LSC_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !m_tvalid, "result offered during reset")

endmodule

`default_nettype wire
